// File: rtl/vic_pkg.sv
// Shared types and constants of the vectored interrupt controller.
`timescale 1ns / 1ps
`default_nettype none
package vic_pkg;

  localparam int CMD_W       = 3;
  localparam int SRC_W       = 8;
  localparam int DATA_W      = 32;
  localparam int BANK_SEL_W  = 2;
  localparam int CFG_INDEX_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENABLE  = 3'd0,
    CMD_DISABLE = 3'd1,
    CMD_SETVEC  = 3'd2,
    CMD_RAISE   = 3'd3,
    CMD_LOWER   = 3'd4,
    CMD_ACK     = 3'd5,
    CMD_CLEAR   = 3'd6,
    CMD_STATUS  = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_EXEC   = 2'd1,
    ST_FINISH = 2'd2
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic exec;
    logic finish;
  } ctrl_cmd_t;

endpackage
`default_nettype wire

// File: rtl/vic_ctrl.sv
// Sequencing state machine of the vectored interrupt controller.
`timescale 1ns / 1ps
`default_nettype none
module vic_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output vic_pkg::ctrl_cmd_t ctrl_o
);

  vic_pkg::ctrl_state_e state_q, state_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vic_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = vic_pkg::ST_EXEC;
      end
      vic_pkg::ST_EXEC: begin
        state_d = vic_pkg::ST_FINISH;
      end
      vic_pkg::ST_FINISH: begin
        if (out_free) state_d = vic_pkg::ST_IDLE;
      end
      default: begin
        state_d = vic_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl_o     = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      vic_pkg::ST_IDLE: begin
        in_stall_o  = 1'b0;
        ctrl_o.load = in_valid_i;
      end
      vic_pkg::ST_EXEC: begin
        ctrl_o.exec = 1'b1;
      end
      vic_pkg::ST_FINISH: begin
        ctrl_o.finish = out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (state_q == vic_pkg::ST_FINISH && out_free) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vic_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// File: rtl/vic_datapath.sv
// Source state, vector memory, priority encoder and result registers.
`timescale 1ns / 1ps
`default_nettype none
module vic_datapath #(
  parameter int SOURCES_PER_BANK = 32,
  parameter int BANK_COUNT       = 4,
  parameter int VECTOR_WIDTH     = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  vic_pkg::ctrl_cmd_t               ctrl_i,
  input  logic [vic_pkg::CMD_W-1:0]        command_i,
  input  logic [vic_pkg::SRC_W-1:0]        source_index_i,
  input  logic [vic_pkg::DATA_W-1:0]       vector_value_i,
  input  logic [vic_pkg::BANK_SEL_W-1:0]   bank_index_i,
  input  logic                             cfg_we_i,
  input  logic [vic_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [vic_pkg::DATA_W-1:0]       cfg_data_i,
  output logic [vic_pkg::DATA_W-1:0]       read_data_o,
  output logic                             irq_request_o,
  output logic                             fiq_request_o,
  output logic [vic_pkg::SRC_W-1:0]        active_source_o
);

  localparam int ALL_SOURCES = SOURCES_PER_BANK * BANK_COUNT;
  localparam int SRC_AW      = $clog2(ALL_SOURCES);
  localparam int BANK_AW     = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;
  localparam int BIT_AW      = $clog2(SOURCES_PER_BANK);

  vic_pkg::cmd_e                       cmd_q;
  logic [vic_pkg::SRC_W-1:0]           src_q;
  logic [VECTOR_WIDTH-1:0]             vec_q;
  logic [vic_pkg::BANK_SEL_W-1:0]      bank_sel_q;

  logic [BANK_COUNT-1:0][SOURCES_PER_BANK-1:0] raw_q, raw_d;
  logic [BANK_COUNT-1:0][SOURCES_PER_BANK-1:0] en_q, en_d;
  logic [BANK_COUNT-1:0][SOURCES_PER_BANK-1:0] fsel_q;
  logic [BANK_COUNT-1:0][SOURCES_PER_BANK-1:0] irq_all;
  logic [BANK_COUNT-1:0][SOURCES_PER_BANK-1:0] fiq_all;
  logic [ALL_SOURCES-1:0]                      irq_flat;

  logic [VECTOR_WIDTH-1:0]   vec_mem [ALL_SOURCES];
  logic [ALL_SOURCES-1:0]    vld_q;
  logic [VECTOR_WIDTH-1:0]   rd_q;
  logic                      rd_vld_q;
  logic                      ack_hit_q;

  logic [vic_pkg::SRC_W-1:0] cur_q, cur_d;

  logic                      in_range;
  logic [BANK_AW-1:0]        bank_idx;
  logic [vic_pkg::SRC_W-1:0] src_off;
  logic [BIT_AW-1:0]         bit_idx;
  logic [SRC_AW-1:0]         src_addr;
  logic                      ack_hit;
  logic [SRC_AW-1:0]         ack_idx;
  logic                      mem_we;
  logic                      mem_re;

  logic [vic_pkg::DATA_W-1:0] rdata;
  logic [vic_pkg::DATA_W-1:0] read_data_q;
  logic                       irq_req_q;
  logic                       fiq_req_q;
  logic [vic_pkg::SRC_W-1:0]  active_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q      <= vic_pkg::cmd_e'(command_i);
      src_q      <= source_index_i;
      vec_q      <= VECTOR_WIDTH'(vector_value_i);
      bank_sel_q <= bank_index_i;
    end
  end

  assign in_range = src_q < vic_pkg::SRC_W'(ALL_SOURCES);
  assign src_addr = src_q[SRC_AW-1:0];

  always_comb begin
    bank_idx = '0;
    src_off  = src_q;
    for (int k = 1; k < BANK_COUNT; k++) begin
      if (src_q >= vic_pkg::SRC_W'(k * SOURCES_PER_BANK)) begin
        bank_idx = BANK_AW'(k);
        src_off  = src_q - vic_pkg::SRC_W'(k * SOURCES_PER_BANK);
      end
    end
  end

  assign bit_idx = src_off[BIT_AW-1:0];

  assign irq_all  = raw_q & en_q & ~fsel_q;
  assign fiq_all  = raw_q & en_q & fsel_q;
  assign irq_flat = irq_all;

  always_comb begin
    ack_hit = 1'b0;
    ack_idx = '0;
    for (int i = ALL_SOURCES - 1; i >= 0; i--) begin
      if (irq_flat[i]) begin
        ack_hit = 1'b1;
        ack_idx = SRC_AW'(i);
      end
    end
  end

  always_comb begin
    raw_d  = raw_q;
    en_d   = en_q;
    cur_d  = cur_q;
    mem_we = 1'b0;
    mem_re = 1'b0;
    if (ctrl_i.exec) begin
      unique case (cmd_q)
        vic_pkg::CMD_ENABLE: begin
          if (in_range) en_d[bank_idx][bit_idx] = 1'b1;
          else          en_d = '1;
        end
        vic_pkg::CMD_DISABLE: begin
          if (in_range) en_d[bank_idx][bit_idx] = 1'b0;
          else          en_d = '0;
        end
        vic_pkg::CMD_SETVEC: begin
          mem_we = in_range;
        end
        vic_pkg::CMD_RAISE: begin
          if (in_range) raw_d[bank_idx][bit_idx] = 1'b1;
        end
        vic_pkg::CMD_LOWER: begin
          if (in_range) raw_d[bank_idx][bit_idx] = 1'b0;
        end
        vic_pkg::CMD_ACK: begin
          mem_re = 1'b1;
          if (ack_hit) cur_d = vic_pkg::SRC_W'(ack_idx);
        end
        vic_pkg::CMD_CLEAR: begin
          cur_d = vic_pkg::SRC_W'(ALL_SOURCES);
        end
        vic_pkg::CMD_STATUS: begin
          cur_d = cur_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q    <= '0;
      en_q     <= '0;
      fsel_q   <= '0;
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      cur_q    <= vic_pkg::SRC_W'(ALL_SOURCES);
    end else begin
      raw_q <= raw_d;
      en_q  <= en_d;
      cur_q <= cur_d;
      if (cfg_we_i && int'(cfg_index_i) < BANK_COUNT) begin
        fsel_q[cfg_index_i[BANK_AW-1:0]] <= cfg_data_i[SOURCES_PER_BANK-1:0];
      end
      if (mem_we) vld_q[src_addr] <= 1'b1;
      if (mem_re) rd_vld_q <= vld_q[ack_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) vec_mem[src_addr] <= vec_q;
    if (mem_re) begin
      rd_q      <= vec_mem[ack_idx];
      ack_hit_q <= ack_hit;
    end
  end

  always_comb begin
    rdata = '0;
    case (cmd_q)
      vic_pkg::CMD_ACK: begin
        if (ack_hit_q && rd_vld_q) rdata = vic_pkg::DATA_W'(rd_q);
      end
      vic_pkg::CMD_STATUS: begin
        if (int'(bank_sel_q) < BANK_COUNT) begin
          rdata = vic_pkg::DATA_W'(irq_all[bank_sel_q[BANK_AW-1:0]]);
        end
      end
      default: begin
        rdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.finish) begin
      read_data_q <= rdata;
      irq_req_q   <= |irq_all;
      fiq_req_q   <= |fiq_all;
      active_q    <= cur_q;
    end
  end

  assign read_data_o     = read_data_q;
  assign irq_request_o   = irq_req_q;
  assign fiq_request_o   = fiq_req_q;
  assign active_source_o = active_q;

endmodule
`default_nettype wire

// File: rtl/vectored_interrupt_controller_top.sv
// Top level of the vectored interrupt controller.
`timescale 1ns / 1ps
`default_nettype none
// Banked interrupt controller: BANK_COUNT banks of SOURCES_PER_BANK sources,
// each with raw line, enable, FIQ routing bit and a stored vector. Every
// command yields one result transfer. An accepted command is first captured,
// then it updates the source state or reads the vector memory at the
// highest-priority pending source (first bank with IRQ status, lowest source
// within it), and then its result is registered, which waits while the output
// side stalls. A new command is taken once the previous one has registered its
// result, so commands do not overlap. Vectors never written read as zero.
module vectored_interrupt_controller_top #(
  parameter int SOURCES_PER_BANK = 32,
  parameter int BANK_COUNT       = 4,
  parameter int VECTOR_WIDTH     = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [vic_pkg::CMD_W-1:0]         command_i,
  input  logic [vic_pkg::SRC_W-1:0]         source_index_i,
  input  logic [vic_pkg::DATA_W-1:0]        vector_value_i,
  input  logic [vic_pkg::BANK_SEL_W-1:0]    bank_index_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [vic_pkg::DATA_W-1:0]        read_data_o,
  output logic                              irq_request_o,
  output logic                              fiq_request_o,
  output logic [vic_pkg::SRC_W-1:0]         active_source_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [vic_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  logic [vic_pkg::DATA_W-1:0]        cfg_data_i
);

  vic_pkg::ctrl_cmd_t ctrl;

  assign cfg_ready_o = 1'b1;

  vic_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ctrl_o      (ctrl)
  );

  vic_datapath #(
    .SOURCES_PER_BANK (SOURCES_PER_BANK),
    .BANK_COUNT       (BANK_COUNT),
    .VECTOR_WIDTH     (VECTOR_WIDTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .command_i       (command_i),
    .source_index_i  (source_index_i),
    .vector_value_i  (vector_value_i),
    .bank_index_i    (bank_index_i),
    .cfg_we_i        (cfg_valid_i & cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .read_data_o     (read_data_o),
    .irq_request_o   (irq_request_o),
    .fiq_request_o   (fiq_request_o),
    .active_source_o (active_source_o)
  );

endmodule
`default_nettype wire
